### design/ffua_pkg.sv
// Package for the first-fit unit allocator.
// Holds map geometry, field widths, operation and status codes, and the
// sequencer state type. No dependencies.
package ffua_pkg;

   // Map geometry
   localparam int MEM_UNITS = 32;
   localparam int AW        = $clog2(MEM_UNITS);        // unit address width
   localparam int RW        = $clog2(MEM_UNITS + 1);    // run length width

   // Field widths
   localparam int TAG_W  = 8;
   localparam int SIZE_W = 6;
   // Width wide enough to compare a requested size against the map size
   localparam int CMP_W  = (RW > SIZE_W) ? RW : SIZE_W;

   localparam logic [TAG_W-1:0] FREE_TAG = '0;

   // Operation codes
   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // Status codes
   localparam logic ST_OK   = 1'b0;
   localparam logic ST_FAIL = 1'b1;

   // Sequencer states, one-hot
   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_FILL = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

endpackage

### design/ffua_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the unit owner map. No dependencies.
module ffua_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/first_fit_unit_allocator.sv
// First-fit unit allocator, top level.
// Depends on ffua_pkg and ffua_ram.
//
// Usage:
//   Request channel (req_valid / req_stall, fields req_op, req_owner,
//   req_size): req_op = 0 allocates req_size contiguous units under tag
//   req_owner, taking the lowest-addressed run of free units that fits;
//   req_op = 1 frees every unit tagged req_owner.
//   Response channel (rsp_valid / rsp_stall, field rsp_status): one
//   transfer per request, 0 on success, 1 on no room or owner not found.
//   The map is scanned one unit per cycle through the single RAM
//   read port, which has registered read data. A release scans the whole
//   map before it responds; an allocate scans up to the end unit of the
//   chosen run, or the whole map on no room, then tags the run; the tag
//   writes go through the single RAM write port one unit per cycle. A
//   request with a zero owner, or an allocate with a zero or oversized
//   size, is answered with 1 without a scan. One request is in flight at a time; req_stall is
//   high from acceptance until the response is loaded into the output
//   register, so a new request can be taken while that response waits.
//   If the receiver stalls with a response pending, the next request
//   finishes its work and holds until the output register frees.
//   Reset: synchronous; all units read as free at once (per-unit valid
//   bits), no clearing pass.
module first_fit_unit_allocator
   import ffua_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_op,
   input  logic [TAG_W-1:0]  req_owner,
   input  logic [SIZE_W-1:0] req_size,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_status
);

   localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_UNITS - 1);

   state_type state_ff, state_in;

   // Request registers
   logic              op_ff, op_in;
   logic [TAG_W-1:0]  owner_ff, owner_in;
   logic [RW-1:0]     want_ff, want_in;

   // Scan pipeline: read issue, then check stage
   logic [AW-1:0]     rd_addr_ff, rd_addr_in;
   logic              issue_ff, issue_in;
   logic              chk_vld_ff, chk_vld_in;
   logic [AW-1:0]     chk_addr_ff, chk_addr_in;
   logic [RW-1:0]     run_ff, run_in;
   logic              found_ff, found_in;
   logic              status_ff, status_in;

   // Fill pointer
   logic [AW-1:0]     fill_addr_ff, fill_addr_in;
   logic [AW-1:0]     end_addr_ff, end_addr_in;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_status_ff, rsp_status_in;

   // Per-unit written bits; an unwritten unit reads as free
   logic [MEM_UNITS-1:0] valid_ff, valid_in;
   logic                 valid_rd_ff;

   // RAM port signals
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [TAG_W-1:0]  ram_wr_data;
   logic              ram_rd_en;
   logic [TAG_W-1:0]  ram_rd_data;

   logic [TAG_W-1:0]  unit_val;
   logic              req_bad;
   logic [RW-1:0]     run_next;

   ffua_ram #(
      .WIDTH (TAG_W),
      .DEPTH (MEM_UNITS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_addr_ff),
      .rd_data (ram_rd_data)
   );

   // Unit tag at the check stage
   assign unit_val = valid_rd_ff ? ram_rd_data : FREE_TAG;
   assign run_next = run_ff + RW'(1);

   // Requests that never touch the map
   always_comb begin
      if (req_op == OP_ALLOC) begin
         req_bad = (req_owner == FREE_TAG) || (req_size == '0) ||
                   (CMP_W'(req_size) > CMP_W'(MEM_UNITS));
      end else begin
         req_bad = (req_owner == FREE_TAG);
      end
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      owner_in      = owner_ff;
      want_in       = want_ff;
      rd_addr_in    = rd_addr_ff;
      issue_in      = issue_ff;
      chk_vld_in    = 1'b0;
      chk_addr_in   = rd_addr_ff;
      run_in        = run_ff;
      found_in      = found_ff;
      status_in     = status_ff;
      fill_addr_in  = fill_addr_ff;
      end_addr_in   = end_addr_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = chk_addr_ff;
      ram_wr_data   = FREE_TAG;
      ram_rd_en     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in      = req_op;
               owner_in   = req_owner;
               want_in    = RW'(req_size);
               rd_addr_in = '0;
               issue_in   = 1'b1;
               run_in     = '0;
               found_in   = 1'b0;
               if (req_bad) begin
                  status_in = ST_FAIL;
                  state_in  = S_DONE;
               end else begin
                  state_in  = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            // issue one read per cycle
            if (issue_ff) begin
               ram_rd_en   = 1'b1;
               chk_vld_in  = 1'b1;
               chk_addr_in = rd_addr_ff;
               if (rd_addr_ff == LAST_ADDR) begin
                  issue_in = 1'b0;
               end else begin
                  rd_addr_in = rd_addr_ff + AW'(1);
               end
            end
            // check the unit read last cycle
            if (chk_vld_ff) begin
               if (op_ff == OP_ALLOC) begin
                  if (unit_val == FREE_TAG) begin
                     if (run_next == want_ff) begin
                        fill_addr_in = chk_addr_ff - AW'(want_ff - RW'(1));
                        end_addr_in  = chk_addr_ff;
                        issue_in     = 1'b0;
                        chk_vld_in   = 1'b0;
                        state_in     = S_FILL;
                     end else begin
                        run_in = run_next;
                     end
                  end else begin
                     run_in = '0;
                  end
                  if ((unit_val != FREE_TAG || run_next != want_ff) &&
                      chk_addr_ff == LAST_ADDR) begin
                     status_in = ST_FAIL;
                     state_in  = S_DONE;
                  end
               end else begin
                  if (unit_val == owner_ff) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_data = FREE_TAG;
                     found_in    = 1'b1;
                  end
                  if (chk_addr_ff == LAST_ADDR) begin
                     status_in = (found_ff || unit_val == owner_ff) ? ST_OK : ST_FAIL;
                     state_in  = S_DONE;
                  end
               end
            end
         end

         S_FILL: begin
            // tag the chosen run, one unit per cycle
            ram_wr_en   = 1'b1;
            ram_wr_addr = fill_addr_ff;
            ram_wr_data = owner_ff;
            if (fill_addr_ff == end_addr_ff) begin
               status_in = ST_OK;
               state_in  = S_DONE;
            end else begin
               fill_addr_in = fill_addr_ff + AW'(1);
            end
         end

         S_DONE: begin
            // load the output register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Written bits follow RAM writes
   always_comb begin
      valid_in = valid_ff;
      if (ram_wr_en) begin
         valid_in[ram_wr_addr] = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issue_ff     <= 1'b0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      owner_ff      <= owner_in;
      want_ff       <= want_in;
      rd_addr_ff    <= rd_addr_in;
      chk_addr_ff   <= chk_addr_in;
      run_ff        <= run_in;
      found_ff      <= found_in;
      status_ff     <= status_in;
      fill_addr_ff  <= fill_addr_in;
      end_addr_ff   <= end_addr_in;
      rsp_status_ff <= rsp_status_in;
      if (ram_rd_en) begin
         valid_rd_ff <= valid_ff[rd_addr_ff];
      end
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

   // Checks

   // A response only appears after the sequencer finishes an item
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside the done state");

   // Map writes happen only while filling or during a release scan
   a_wr_phase: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == S_FILL ||
                     (state_ff == S_SCAN && op_ff == OP_RELEASE)))
      else $error("map write outside fill or release scan");

   // Fill never writes the free tag
   a_fill_tag: assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && state_ff == S_FILL) |-> (owner_ff != FREE_TAG))
      else $error("fill with free tag");

   // A release write only clears a unit owned by the requester
   a_rel_match: assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && state_ff == S_SCAN) |-> (unit_val == owner_ff))
      else $error("release cleared a unit of another owner");

   // Fill pointer stays inside the chosen run
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL) |-> (fill_addr_ff <= end_addr_ff))
      else $error("fill pointer ran past the run end");

endmodule

### test/first_fit_unit_allocator_test.sv
// Self-checking testbench for first_fit_unit_allocator: directed and random
// allocate/release traffic, checked against a unit-map predictor.
// Depends on ffua_pkg and the allocator RTL.
module first_fit_unit_allocator_test;
   import ffua_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 650;
   localparam int DRAIN_CYCLES = 2 * MEM_UNITS + 8;

   typedef struct {
      logic              op;
      logic [TAG_W-1:0]  owner;
      logic [SIZE_W-1:0] size;
   } alloc_req_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_op = OP_ALLOC;
   logic [TAG_W-1:0]  req_owner = '0;
   logic [SIZE_W-1:0] req_size = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_status;

   // Predictor state: owner tag per unit
   logic [TAG_W-1:0] unit_tags [MEM_UNITS];

   alloc_req_type pending_reqs[$];
   logic          expected_status[$];
   alloc_req_type cur_req;
   int            req_total = 0;
   int            req_accepted = 0;
   int            rsp_count = 0;
   int            gap_left = 0;
   int            stall_left = 0;
   int            fail_count = 0;
   int            cycle_count = 0;

   first_fit_unit_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_op     (req_op),
      .req_owner  (req_owner),
      .req_size   (req_size),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_status (rsp_status)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Every fourth stretch of 80 transfers runs with no idling at all
   function automatic int draw_wait(int n);
      if ((n / 80) % 4 == 3)
         return 0;
      return $urandom_range(0, 8);
   endfunction

   // First-fit allocate or release on the predicted map; returns status
   function automatic logic apply_request(alloc_req_type r);
      int   run;
      logic hit;
      run = 0;
      hit = 1'b0;
      if (r.op == OP_ALLOC) begin
         if (r.owner == FREE_TAG || r.size == 0 || r.size > MEM_UNITS)
            return ST_FAIL;
         for (int i = 0; i < MEM_UNITS; i++) begin
            if (unit_tags[i] == FREE_TAG) begin
               run++;
               if (run == r.size) begin
                  for (int k = i + 1 - run; k <= i; k++)
                     unit_tags[k] = r.owner;
                  return ST_OK;
               end
            end else begin
               run = 0;
            end
         end
         return ST_FAIL;
      end
      if (r.owner == FREE_TAG)
         return ST_FAIL;
      for (int i = 0; i < MEM_UNITS; i++) begin
         if (unit_tags[i] == r.owner) begin
            unit_tags[i] = FREE_TAG;
            hit = 1'b1;
         end
      end
      return hit ? ST_OK : ST_FAIL;
   endfunction

   task automatic add_req(logic op, int owner, int size);
      alloc_req_type r;
      r.op    = op;
      r.owner = owner[TAG_W-1:0];
      r.size  = size[SIZE_W-1:0];
      pending_reqs.push_back(r);
   endtask

   // Owner mostly from a small pool so releases find their units
   function automatic int pick_owner();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(0, 255);
      return $urandom_range(1, 12);
   endfunction

   function automatic int pick_size();
      int s;
      s = $urandom_range(0, 19);
      if (s < 12)
         return $urandom_range(1, 6);
      if (s < 17)
         return $urandom_range(7, 16);
      if (s < 19)
         return $urandom_range(17, 32);
      return $urandom_range(0, 63);
   endfunction

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_status.push_back(apply_request(cur_req));
            req_accepted++;
            gap_left = draw_wait(req_accepted);
         end
         // hold a stalled transfer as it is
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               cur_req = pending_reqs.pop_front();
               req_op    <= cur_req.op;
               req_owner <= cur_req.owner;
               req_size  <= cur_req.size;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and stall generator
   always @(posedge clock) begin
      logic want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (expected_status.size() == 0) begin
               $error("unexpected response transfer, status %0d", rsp_status);
               fail_count++;
            end else begin
               want = expected_status.pop_front();
               if (rsp_status !== want) begin
                  $error("status mismatch: expected %0d, actual %0d", want, rsp_status);
                  fail_count++;
               end
            end
            stall_left = draw_wait(rsp_count);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left > 0);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      alloc_req_type r;
      int            pick;
      for (int i = 0; i < MEM_UNITS; i++)
         unit_tags[i] = FREE_TAG;

      // Directed: empty map, rejected requests, full map, contiguity
      add_req(OP_RELEASE, 5, 0);      // release on empty map
      add_req(OP_ALLOC, 0, 4);        // zero owner
      add_req(OP_ALLOC, 1, 0);        // zero size
      add_req(OP_ALLOC, 1, 33);       // one larger than the map
      add_req(OP_ALLOC, 1, 63);       // all size bits set
      add_req(OP_ALLOC, 255, 32);     // whole map, all owner bits set
      add_req(OP_ALLOC, 1, 1);        // no room
      add_req(OP_RELEASE, 255, 17);
      add_req(OP_RELEASE, 0, 0);      // zero owner release
      add_req(OP_ALLOC, 1, 4);
      add_req(OP_ALLOC, 2, 4);
      add_req(OP_ALLOC, 3, 4);
      add_req(OP_RELEASE, 2, 0);      // hole of four at units 4..7
      add_req(OP_ALLOC, 4, 6);        // must skip the hole
      add_req(OP_ALLOC, 5, 4);        // fills the hole
      add_req(OP_ALLOC, 1, 2);        // owner already present
      add_req(OP_ALLOC, 6, 32);       // no run long enough
      add_req(OP_ALLOC, 7, 12);       // exactly the tail
      add_req(OP_ALLOC, 8, 1);        // map full
      add_req(OP_RELEASE, 1, 0);      // frees both runs of owner 1
      add_req(OP_RELEASE, 1, 0);      // now not found
      add_req(OP_RELEASE, 3, 0);
      add_req(OP_RELEASE, 4, 0);
      add_req(OP_RELEASE, 5, 0);
      add_req(OP_RELEASE, 7, 0);

      // Random: mostly well-formed traffic from a small owner pool
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            r.op    = OP_ALLOC;
            r.owner = TAG_W'(pick_owner());
            r.size  = SIZE_W'(pick_size());
         end else if (pick < 95) begin
            r.op    = OP_RELEASE;
            r.owner = TAG_W'(pick_owner());
            r.size  = SIZE_W'($urandom_range(0, 63));
         end else begin
            r.op    = OP_ALLOC;
            r.owner = TAG_W'($urandom_range(0, 255));
            r.size  = SIZE_W'($urandom_range(0, 63));
         end
         pending_reqs.push_back(r);
      end
      req_total = pending_reqs.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (req_accepted < req_total || expected_status.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_status.size() > 0) begin
         $error("%0d responses never arrived", expected_status.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### files.f
design/ffua_pkg.sv
design/ffua_ram.sv
design/first_fit_unit_allocator.sv
test/first_fit_unit_allocator_test.sv
